/* rtl/mfs_pkg.sv */
// mfs_pkg: shared types and constants for the maximum frequency stack
// depends on: nothing

package mfs_pkg;

    localparam int VALUE_W   = 32;
    localparam int OUT_LVL_W = 7;
    localparam int STATUS_W  = 2;

    // request kinds
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // control broadcast to every cell of the ring
    typedef struct packed {
        logic shift;
        logic wr;
    } ring_ctl_t;

endpackage

/* rtl/mfs_cell.sv */
// mfs_cell: one storage cell of the rotating entry ring
// depends on: mfs_pkg

module mfs_cell #(
    parameter int LVL_W = 7,
    parameter int IDX_W = 6,
    parameter int IDX   = 0
) (
    input  logic                            aclk,
    input  mfs_pkg::ring_ctl_t              ctl,
    input  logic [mfs_pkg::VALUE_W-1:0]     in_value,
    input  logic [LVL_W-1:0]                in_level,
    input  logic [IDX_W-1:0]                wr_idx,
    input  logic [mfs_pkg::VALUE_W-1:0]     wr_value,
    input  logic [LVL_W-1:0]                wr_level,
    output logic [mfs_pkg::VALUE_W-1:0]     out_value,
    output logic [LVL_W-1:0]                out_level
);

    logic [mfs_pkg::VALUE_W-1:0] val_reg;
    logic [LVL_W-1:0]            lvl_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr && (wr_idx == IDX_W'(IDX))) begin
            val_reg <= wr_value;
            lvl_reg <= wr_level;
        end else if (ctl.shift) begin
            val_reg <= in_value;
            lvl_reg <= in_level;
        end
    end

    assign out_value = val_reg;
    assign out_level = lvl_reg;

endmodule

/* rtl/mfs_ctrl.sv */
// mfs_ctrl: request sequencer, scan logic and result register
// depends on: mfs_pkg

module mfs_ctrl #(
    parameter int DEPTH = 64,
    parameter int LVL_W = 7,
    parameter int CNT_W = 6
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic                                s_func,
    input  logic [mfs_pkg::VALUE_W-1:0]         s_value,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mfs_pkg::VALUE_W-1:0]         m_value,
    output logic [mfs_pkg::OUT_LVL_W-1:0]       m_level,
    output logic [mfs_pkg::STATUS_W-1:0]        m_status,
    input  logic [mfs_pkg::VALUE_W-1:0]         tail_value,
    input  logic [LVL_W-1:0]                    tail_level,
    output logic [mfs_pkg::VALUE_W-1:0]         feed_value,
    output logic [LVL_W-1:0]                    feed_level,
    output mfs_pkg::ring_ctl_t                  ring_ctl,
    output logic [CNT_W-1:0]                    wr_idx,
    output logic [mfs_pkg::VALUE_W-1:0]         wr_value,
    output logic [LVL_W-1:0]                    wr_level
);

    typedef enum logic [1:0] {IDLE, SCAN, WRITE, FINISH} state_t;

    localparam logic [CNT_W-1:0] LAST_CNT  = CNT_W'(DEPTH - 1);
    localparam logic [LVL_W-1:0] LAST_SLOT = LVL_W'(DEPTH - 1);
    localparam logic [LVL_W-1:0] FULL_CNT  = LVL_W'(DEPTH);
    localparam int               WIDE_W    = LVL_W + mfs_pkg::OUT_LVL_W;

    state_t                          state_reg;
    logic                            op_reg;
    logic [mfs_pkg::VALUE_W-1:0]     value_reg;
    logic [CNT_W-1:0]                cnt_reg;
    logic [LVL_W-1:0]                live_reg;
    logic [LVL_W-1:0]                top_reg;
    logic [LVL_W-1:0]                copies_reg;
    logic                            found_reg;
    logic                            remain_reg;
    logic [mfs_pkg::VALUE_W-1:0]     hold_value_reg;
    logic [LVL_W-1:0]                hold_level_reg;
    logic [mfs_pkg::VALUE_W-1:0]     res_value_reg;
    logic [LVL_W-1:0]                res_level_reg;
    logic [mfs_pkg::STATUS_W-1:0]    res_status_reg;
    logic                            m_tvalid_reg;
    logic [mfs_pkg::VALUE_W-1:0]     m_value_reg;
    logic [mfs_pkg::OUT_LVL_W-1:0]   m_level_reg;
    logic [mfs_pkg::STATUS_W-1:0]    m_status_reg;

    logic [LVL_W-1:0]  slot_idx;
    logic              slot_live;
    logic              top_hit;
    logic              remain_now;
    logic [LVL_W-1:0]  new_lvl;
    logic [WIDE_W-1:0] res_level_wide;

    // entry leaving the tail is slot DEPTH-1-cnt, newest slots first
    assign slot_idx       = LAST_SLOT - LVL_W'(cnt_reg);
    assign slot_live      = slot_idx < live_reg;
    assign top_hit        = slot_live && (tail_level == top_reg);
    assign remain_now     = remain_reg || (found_reg && top_hit);
    assign new_lvl        = copies_reg + LVL_W'(1);
    assign res_level_wide = WIDE_W'(res_level_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= IDLE;
            live_reg     <= '0;
            top_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // in FINISH the output register is reloaded below instead
            if (m_tvalid_reg && m_tready && (state_reg != FINISH)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                IDLE: begin
                    if (s_tvalid) begin
                        op_reg     <= s_func;
                        value_reg  <= s_value;
                        cnt_reg    <= '0;
                        copies_reg <= '0;
                        found_reg  <= 1'b0;
                        remain_reg <= 1'b0;
                        if (s_func == mfs_pkg::OP_PUSH) begin
                            if (live_reg == FULL_CNT) begin
                                res_value_reg  <= '0;
                                res_level_reg  <= '0;
                                res_status_reg <= mfs_pkg::ST_FULL;
                                state_reg      <= FINISH;
                            end else begin
                                state_reg <= SCAN;
                            end
                        end else begin
                            if (live_reg == '0) begin
                                res_value_reg  <= '0;
                                res_level_reg  <= '0;
                                res_status_reg <= mfs_pkg::ST_EMPTY;
                                state_reg      <= FINISH;
                            end else begin
                                state_reg <= SCAN;
                            end
                        end
                    end
                end
                SCAN: begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (op_reg == mfs_pkg::OP_PUSH) begin
                        if (slot_live && (tail_value == value_reg)) begin
                            copies_reg <= copies_reg + LVL_W'(1);
                        end
                    end else begin
                        hold_value_reg <= tail_value;
                        hold_level_reg <= tail_level;
                        if (!found_reg) begin
                            if (top_hit) begin
                                found_reg     <= 1'b1;
                                res_value_reg <= tail_value;
                                res_level_reg <= tail_level;
                            end
                        end else if (top_hit) begin
                            remain_reg <= 1'b1;
                        end
                    end
                    if (cnt_reg == LAST_CNT) begin
                        if (op_reg == mfs_pkg::OP_PUSH) begin
                            state_reg <= WRITE;
                        end else begin
                            live_reg       <= live_reg - LVL_W'(1);
                            res_status_reg <= mfs_pkg::ST_OK;
                            if (!remain_now && (top_reg != '0)) begin
                                top_reg <= top_reg - LVL_W'(1);
                            end
                            state_reg <= FINISH;
                        end
                    end
                end
                WRITE: begin
                    live_reg       <= live_reg + LVL_W'(1);
                    if (new_lvl > top_reg) begin
                        top_reg <= new_lvl;
                    end
                    res_value_reg  <= value_reg;
                    res_level_reg  <= new_lvl;
                    res_status_reg <= mfs_pkg::ST_OK;
                    state_reg      <= FINISH;
                end
                FINISH: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_value_reg  <= res_value_reg;
                        m_level_reg  <= res_level_wide[mfs_pkg::OUT_LVL_W-1:0];
                        m_status_reg <= res_status_reg;
                        state_reg    <= IDLE;
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    // on pop, entries are fed through the hold register until the pick has passed, which drops it
    always_comb begin
        if ((op_reg == mfs_pkg::OP_POP) && !found_reg) begin
            feed_value = hold_value_reg;
            feed_level = hold_level_reg;
        end else begin
            feed_value = tail_value;
            feed_level = tail_level;
        end
    end

    assign ring_ctl.shift = (state_reg == SCAN);
    assign ring_ctl.wr    = (state_reg == WRITE);
    assign wr_idx         = live_reg[CNT_W-1:0];
    assign wr_value       = value_reg;
    assign wr_level       = new_lvl;

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_value  = m_value_reg;
    assign m_level  = m_level_reg;
    assign m_status = m_status_reg;

endmodule

/* rtl/max_frequency_stack.sv */
// max_frequency_stack: top level, ring of entry cells plus request sequencer
// depends on: mfs_pkg, mfs_cell, mfs_ctrl

// A push stores a value with a level one above the number of live copies of
// that value and echoes value and level; a pop returns the newest entry at the
// highest level. Entries sit in a ring of DEPTH cells that rotates one cell per
// cycle while a request is scanned; the sequencer watches the entry leaving the
// last cell, so each push or pop takes a full turn of the ring, and errors (pop
// when empty, push when full) skip the turn. One request is in work at a time;
// s_tready is high whenever the sequencer is idle, even while a result still
// waits in the output register. No clearing pass is needed after reset.

module max_frequency_stack #(
    parameter int DEPTH = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    // request channel
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // [31:0] value
    input  logic [0:0]   s_tuser,   // [0] func
    // result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata,   // [31:0] out_value, [38:32] out_level, [39] zero
    output logic [1:0]   m_tuser    // [1:0] status
);

    // level and count widths follow the depth
    localparam int LVL_W = $clog2(DEPTH + 1);
    localparam int CNT_W = $clog2(DEPTH);

    // ring links: cell i feeds cell i+1, the last cell feeds the sequencer
    logic [mfs_pkg::VALUE_W-1:0] chain_value [DEPTH];
    logic [LVL_W-1:0]            chain_level [DEPTH];

    logic [mfs_pkg::VALUE_W-1:0]   feed_value;
    logic [LVL_W-1:0]              feed_level;
    mfs_pkg::ring_ctl_t            ring_ctl;
    logic [CNT_W-1:0]              wr_idx;
    logic [mfs_pkg::VALUE_W-1:0]   wr_value;
    logic [LVL_W-1:0]              wr_level;
    logic [mfs_pkg::VALUE_W-1:0]   m_value;
    logic [mfs_pkg::OUT_LVL_W-1:0] m_level;
    logic [mfs_pkg::STATUS_W-1:0]  m_status;

    // sequencer: handshakes, match counting, pick and drop during the turn
    mfs_ctrl #(
        .DEPTH (DEPTH),
        .LVL_W (LVL_W),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_func     (s_tuser[0]),
        .s_value    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_value    (m_value),
        .m_level    (m_level),
        .m_status   (m_status),
        .tail_value (chain_value[DEPTH-1]),
        .tail_level (chain_level[DEPTH-1]),
        .feed_value (feed_value),
        .feed_level (feed_level),
        .ring_ctl   (ring_ctl),
        .wr_idx     (wr_idx),
        .wr_value   (wr_value),
        .wr_level   (wr_level)
    );

    // ring of cells; at rest cell i holds slot i in push order
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_head
            mfs_cell #(
                .LVL_W (LVL_W),
                .IDX_W (CNT_W),
                .IDX   (i)
            ) u_cell (
                .aclk      (aclk),
                .ctl       (ring_ctl),
                .in_value  (feed_value),
                .in_level  (feed_level),
                .wr_idx    (wr_idx),
                .wr_value  (wr_value),
                .wr_level  (wr_level),
                .out_value (chain_value[i]),
                .out_level (chain_level[i])
            );
        end else begin : g_body
            mfs_cell #(
                .LVL_W (LVL_W),
                .IDX_W (CNT_W),
                .IDX   (i)
            ) u_cell (
                .aclk      (aclk),
                .ctl       (ring_ctl),
                .in_value  (chain_value[i-1]),
                .in_level  (chain_level[i-1]),
                .wr_idx    (wr_idx),
                .wr_value  (wr_value),
                .wr_level  (wr_level),
                .out_value (chain_value[i]),
                .out_level (chain_level[i])
            );
        end
    end

    // pack the result transaction
    assign m_tdata = {1'b0, m_level, m_value};
    assign m_tuser = m_status;

endmodule
